// ===== rtl/ppmfg_pkg.sv =====
// Shared types and constants for the PPM frame generator.
package ppmfg_pkg;

  // Field widths of the item and register payloads.
  localparam int GAP_W    = 12;
  localparam int FRAME_W  = 16;
  localparam int WIDTH_W  = 14;
  localparam int SLOT_W   = 4;
  localparam int CHAN_W   = 4;
  localparam int SUM_W    = 18;
  localparam int COUNT_W  = 17;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;

  // Default channel count of a frame.
  localparam int CHANNELS_DEFAULT = 9;

  // Register reset values.
  localparam logic [GAP_W-1:0]   GAP_RESET   = 12'd400;
  localparam logic [FRAME_W-1:0] FRAME_RESET = 16'd20000;

  // The sync part is rounded down to a multiple of this many microseconds.
  // Division by it is a multiply by a rounded-up reciprocal and a shift,
  // exact for any 16-bit dividend.
  localparam int SYNC_STEP  = 100;
  localparam int SYNC_SHIFT = 23;
  localparam int SYNC_RECIP = (2**SYNC_SHIFT + SYNC_STEP - 1) / SYNC_STEP;
  localparam int REST_W     = 16;
  localparam int RECIP_W    = 17;
  localparam int QUOT_W     = 10;

  // Item operation codes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_AW-1:0] {
    REG_GAP   = 2'd0,
    REG_FRAME = 2'd1
  } reg_idx_t;

  // One input item.
  typedef struct packed {
    logic               op;
    logic [CHAN_W-1:0]  channel;
    logic [WIDTH_W-1:0] width_us;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic              ppm_level;
    logic              frame_start;
    logic [SLOT_W-1:0] slot;
  } out_item_t;

endpackage

// ===== rtl/ppmfg_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ppmfg_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 9
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ppm_frame_generator.sv =====
// PPM frame generator: pulse-position-modulated RC frames driven by microsecond ticks.
//
// Each tick item yields one result, and a new item can be taken every cycle
// unless an earlier tick is still at work. The sequencer moves through one
// phase per cycle while a tick is pending, and every phase of zero length
// that a tick has to skip (a high part no longer than the gap, a zero gap,
// the empty closing high part, the sync low part) is passed on the way to
// its result. A width write gives no result.
// Channel widths live in two small memories: one holds the latest pending
// width per channel for the running sum, the other holds two banks per
// channel so that the widths latched at frame start stay put while new
// widths are written. Per-entry valid bits make both read as zero after
// reset, so there is no clearing pass. The sync length is computed in three
// registered steps after frame start and is always ready before the sync
// slot is reached. Configuration writes are always taken (cfg_ready is high).
module ppm_frame_generator #(
  parameter int CHANNELS = ppmfg_pkg::CHANNELS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ppmfg_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ppmfg_pkg::out_item_t              out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppmfg_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [ppmfg_pkg::CFG_DW-1:0]      cfg_data
);

  localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BDEPTH  = 2 << AW;
  localparam int SW      = $clog2(CHANNELS + 2);
  localparam int MAX_ADV = 4 * (CHANNELS + 2) + 4;
  localparam int ACW     = $clog2(MAX_ADV);
  localparam int WW      = ppmfg_pkg::WIDTH_W;
  localparam int GW      = ppmfg_pkg::GAP_W;
  localparam int CW      = ppmfg_pkg::COUNT_W;
  localparam int PW      = ppmfg_pkg::REST_W + ppmfg_pkg::RECIP_W;

  localparam logic [SW-1:0]  SLOT_CLOSE = SW'(CHANNELS);
  localparam logic [SW-1:0]  SLOT_SYNC  = SW'(CHANNELS + 1);
  localparam logic [ppmfg_pkg::CHAN_W:0] CH_LIMIT = (ppmfg_pkg::CHAN_W + 1)'(CHANNELS);
  localparam logic [ACW-1:0] ADV_LAST   = ACW'(MAX_ADV - 1);

  // Configuration registers.
  logic [GW-1:0]                  gap_r;
  logic [ppmfg_pkg::FRAME_W-1:0]  frame_r;

  // Input decode.
  logic          accept;
  logic          wr_req;
  logic [AW-1:0] in_idx;

  // Pending-width memory and the running sum.
  logic [WW-1:0]               p_rdata;
  logic                        wr2_v_r;
  logic [AW-1:0]               wr2_idx_r;
  logic [WW-1:0]               wr2_w_r;
  logic                        fwd_v_r;
  logic [AW-1:0]               fwd_idx_r;
  logic [WW-1:0]               fwd_w_r;
  logic [CHANNELS-1:0]         pv_r;
  logic [ppmfg_pkg::SUM_W-1:0] sum_r;
  logic [WW-1:0]               old_w;

  // Banked active-width memory.
  logic [AW:0]         b_wr_addr;
  logic [BDEPTH-1:0]   av_r;
  logic [CHANNELS-1:0] cur_r;
  logic [CHANNELS-1:0] act_sel_r;
  logic                b_rd_en;
  logic [AW-1:0]       b_rd_idx;
  logic                b_rd_bank;
  logic [AW:0]         b_rd_addr;
  logic [WW-1:0]       b_rdata;
  logic                act_ok_r;
  logic [WW-1:0]       act_w;

  // Phase sequencer.
  logic           tick_pend_r;
  logic [SW-1:0]  slot_r;
  logic [SW-1:0]  next_slot;
  logic           high_r;
  logic [CW-1:0]  count_r;
  logic           started_r;
  logic [ACW-1:0] adv_r;
  logic [CW-1:0]  sync_len_r;
  logic [CW-1:0]  phase_len;
  logic           hit;
  logic           last_try;
  logic           out_free;
  logic           emit;
  logic           advance;
  logic           begin_fr;

  // Sync length pipeline.
  logic                         sp0_v_r;
  logic                         sp1_v_r;
  logic [ppmfg_pkg::REST_W-1:0] rest_r;
  logic [ppmfg_pkg::QUOT_W-1:0] q_r;
  logic [19:0]                  diff;
  logic [PW-1:0]                prod;

  // Result register.
  logic                 out_valid_r;
  ppmfg_pkg::out_item_t out_r;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r   <= ppmfg_pkg::GAP_RESET;
      frame_r <= ppmfg_pkg::FRAME_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        ppmfg_pkg::REG_GAP:   gap_r   <= cfg_data[GW-1:0];
        ppmfg_pkg::REG_FRAME: frame_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A transfer is held back only while an earlier tick is still at work.
  assign in_stall = tick_pend_r && !emit;
  assign accept   = in_valid && !in_stall;
  assign in_idx   = in_data.channel[AW-1:0];
  assign wr_req   = accept && (in_data.op == ppmfg_pkg::OP_WRITE) &&
                    ({1'b0, in_data.channel} < CH_LIMIT);

  // Pending widths: read at transfer, update sum and write back in the following cycle.
  ppmfg_ram #(
    .WIDTH (WW),
    .DEPTH (CHANNELS)
  ) u_pend_ram (
    .clk     (clk),
    .wr_en   (wr2_v_r),
    .wr_addr (wr2_idx_r),
    .wr_data (wr2_w_r),
    .rd_en   (wr_req),
    .rd_addr (in_idx),
    .rd_data (p_rdata)
  );

  // The previous write may hit the entry that was read in the same cycle.
  always_comb begin
    if (fwd_v_r && (fwd_idx_r == wr2_idx_r)) begin
      old_w = fwd_w_r;
    end else if (pv_r[wr2_idx_r]) begin
      old_w = p_rdata;
    end else begin
      old_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr2_v_r <= 1'b0;
      fwd_v_r <= 1'b0;
      pv_r    <= '0;
      sum_r   <= '0;
    end else begin
      wr2_v_r <= wr_req;
      fwd_v_r <= wr2_v_r;
      if (wr2_v_r) begin
        pv_r[wr2_idx_r] <= 1'b1;
        sum_r <= sum_r - ppmfg_pkg::SUM_W'(old_w) + ppmfg_pkg::SUM_W'(wr2_w_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_req) begin
      wr2_idx_r <= in_idx;
      wr2_w_r   <= in_data.width_us;
    end
    fwd_idx_r <= wr2_idx_r;
    fwd_w_r   <= wr2_w_r;
  end

  // New widths go to the bank that the running frame does not use.
  assign b_wr_addr = {~act_sel_r[in_idx], in_idx};

  // Active width read: issued when the sequencer enters a channel slot.
  assign next_slot = slot_r + 1'b1;
  assign begin_fr  = advance && high_r && (slot_r == SLOT_SYNC);
  assign b_rd_en   = begin_fr ||
                     (advance && high_r && (slot_r != SLOT_SYNC) && (next_slot < SLOT_CLOSE));
  assign b_rd_idx  = begin_fr ? '0 : AW'(next_slot);
  assign b_rd_bank = begin_fr ? cur_r[0] : act_sel_r[b_rd_idx];
  assign b_rd_addr = {b_rd_bank, b_rd_idx};

  ppmfg_ram #(
    .WIDTH (WW),
    .DEPTH (BDEPTH)
  ) u_act_ram (
    .clk     (clk),
    .wr_en   (wr_req),
    .wr_addr (b_wr_addr),
    .wr_data (in_data.width_us),
    .rd_en   (b_rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (b_rdata)
  );

  assign act_w = act_ok_r ? b_rdata : '0;

  // Length of the current phase.
  always_comb begin
    if (slot_r < SLOT_CLOSE) begin
      if (!high_r) begin
        phase_len = CW'(gap_r);
      end else if (act_w > WW'(gap_r)) begin
        phase_len = CW'(act_w - WW'(gap_r));
      end else begin
        phase_len = '0;
      end
    end else if (slot_r == SLOT_CLOSE) begin
      phase_len = high_r ? '0 : CW'(gap_r);
    end else begin
      phase_len = high_r ? sync_len_r : '0;
    end
  end

  // One phase check per cycle unless the output stalls: use a microsecond or move on.
  assign hit      = count_r < phase_len;
  assign last_try = (adv_r == ADV_LAST);
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = tick_pend_r && (hit || last_try) && out_free;
  assign advance  = tick_pend_r && !hit && (!last_try || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_pend_r <= 1'b0;
      slot_r      <= SLOT_SYNC;
      high_r      <= 1'b1;
      count_r     <= '0;
      started_r   <= 1'b0;
      adv_r       <= '0;
      cur_r       <= '0;
      act_sel_r   <= '0;
      av_r        <= '0;
      act_ok_r    <= 1'b0;
    end else begin
      if (accept && (in_data.op == ppmfg_pkg::OP_TICK)) begin
        tick_pend_r <= 1'b1;
      end else if (emit) begin
        tick_pend_r <= 1'b0;
      end

      // Width write into the free bank.
      if (wr_req) begin
        cur_r[in_idx]   <= ~act_sel_r[in_idx];
        av_r[b_wr_addr] <= 1'b1;
      end

      if (b_rd_en) begin
        act_ok_r <= av_r[b_rd_addr];
      end

      // Move to the next phase; past the sync part a new frame starts.
      if (advance) begin
        count_r <= '0;
        adv_r   <= adv_r + 1'b1;
        if (!high_r) begin
          high_r <= 1'b1;
        end else begin
          high_r <= 1'b0;
          if (slot_r == SLOT_SYNC) begin
            slot_r    <= '0;
            started_r <= 1'b1;
            act_sel_r <= cur_r;
          end else begin
            slot_r <= next_slot;
          end
        end
      end

      // Result of the tick; a tick that finds no nonzero phase returns to the reset position.
      if (emit) begin
        adv_r     <= '0;
        started_r <= 1'b0;
        if (hit) begin
          count_r <= count_r + 1'b1;
        end else begin
          slot_r  <= SLOT_SYNC;
          high_r  <= 1'b1;
          count_r <= '0;
        end
      end
    end
  end

  // Sync length: rest of the frame, then divide, then scale back.
  assign diff = 20'(frame_r) - 20'(sum_r) - 20'(gap_r);
  assign prod = PW'(rest_r) * PW'(ppmfg_pkg::SYNC_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp0_v_r    <= 1'b0;
      sp1_v_r    <= 1'b0;
      sync_len_r <= '0;
    end else begin
      sp0_v_r <= begin_fr;
      sp1_v_r <= sp0_v_r;
      if (emit && !hit) begin
        sync_len_r <= '0;
      end else if (sp1_v_r) begin
        sync_len_r <= CW'(q_r) * CW'(ppmfg_pkg::SYNC_STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (begin_fr) begin
      if (diff[19] || (diff == '0)) begin
        rest_r <= '0;
      end else begin
        rest_r <= diff[ppmfg_pkg::REST_W-1:0];
      end
    end
    if (sp0_v_r) begin
      q_r <= prod[ppmfg_pkg::SYNC_SHIFT +: ppmfg_pkg::QUOT_W];
    end
  end

  // Result register; a new result may be loaded while the old one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (hit) begin
        out_r.ppm_level   <= high_r;
        out_r.frame_start <= started_r;
        out_r.slot        <= ppmfg_pkg::SLOT_W'(slot_r);
      end else begin
        out_r.ppm_level   <= 1'b0;
        out_r.frame_start <= 1'b1;
        out_r.slot        <= ppmfg_pkg::SLOT_W'(SLOT_SYNC);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
